// ===== hdl/dpbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbs_pkg
// Shared types and constants of the DCC packet bit serializer.
// ----------------------------------------------------------------------------
package dpbs_pkg;

    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 4;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int PRE_W    = 6;
    localparam int WORD_W   = 32;
    localparam int BITS_W   = 6;
    localparam int PTR_W    = 5;
    localparam int CFG_A_W  = 1;

    localparam logic [BITS_W-1:0] DIRECT_BITS = 6'd32;
    localparam logic [BITS_W-1:0] DATA_BITS   = 6'd9;
    localparam logic [BITS_W-1:0] CHECK_BITS  = 6'd10;

    localparam logic [LEN_W-1:0]  RST_LENGTH   = 5'd2;
    localparam logic [PRE_W-1:0]  RST_PREAMBLE = 6'd16;
    localparam logic [BYTE_W-1:0] RST_ENTRY0   = 8'hFF;
    localparam logic [BYTE_W-1:0] RST_ENTRY    = 8'h00;

    localparam logic [CFG_A_W-1:0] CFG_CUTOUT = 1'd0;
    localparam logic [CFG_A_W-1:0] CFG_DIRECT = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_HEADER = 2'd2,
        KIND_DIRECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]  value;
    } store_wr_t;

    typedef struct packed {
        logic cutout_enable;
        logic direct_mode;
    } mode_t;

endpackage

// ===== hdl/dpbs_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbs channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface dpbs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  byte_index;
    logic [7:0]  byte_value;
    logic [4:0]  packet_length;
    logic [5:0]  preamble_length;
    logic [31:0] direct_word;

    modport source (output valid, kind, byte_index, byte_value, packet_length,
                    preamble_length, direct_word, input ready);
    modport sink   (input valid, kind, byte_index, byte_value, packet_length,
                    preamble_length, direct_word, output ready);
endinterface

interface dpbs_out_if;
    logic valid;
    logic ready;
    logic line_bit;
    logic packet_request;
    logic cutout_pulse;
    logic direct_taken;

    modport source (output valid, line_bit, packet_request, cutout_pulse, direct_taken,
                    input ready);
    modport sink   (input valid, line_bit, packet_request, cutout_pulse, direct_taken,
                    output ready);
endinterface

interface dpbs_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] addr;
    logic [0:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hdl/dpbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbs_ram
// Generic single-write, single-read RAM with registered read (old data).
// ----------------------------------------------------------------------------
module dpbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/dpbs_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbs_store
// Packet byte store: RAM with per-entry valid bits, reset values and a
// write bypass for the entry under the read pointer.
// ----------------------------------------------------------------------------
module dpbs_store import dpbs_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  store_wr_t         wr,
    input  logic [PTR_W-1:0]  rd_ptr_next,
    input  logic [PTR_W-1:0]  rd_ptr,
    output logic [BYTE_W-1:0] rd_byte
);

    localparam int AW = $clog2(MAX_PACKET_BYTES);
    localparam logic [PTR_W:0] DEPTH_P = (PTR_W+1)'(MAX_PACKET_BYTES);

    logic [MAX_PACKET_BYTES-1:0] valid_reg;
    logic                        bypass_hit_reg;
    logic [BYTE_W-1:0]           bypass_data_reg;
    logic [BYTE_W-1:0]           ram_rdata;
    logic                        wr_ok;
    logic                        rd_ok;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;

    assign wr_ok   = wr.en && ({2'b00, wr.idx} < DEPTH_P);
    assign rd_ok   = {1'b0, rd_ptr} < DEPTH_P;
    assign wr_addr = AW'({1'b0, wr.idx});
    assign rd_addr = AW'(rd_ptr);

    dpbs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MAX_PACKET_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (wr_ok),
        .waddr (wr_addr),
        .wdata (wr.value),
        .raddr (AW'(rd_ptr_next)),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            bypass_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            bypass_hit_reg <= wr_ok && ({1'b0, wr.idx} == rd_ptr_next);
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_data_reg <= wr.value;
    end

    always_comb
    begin
        if (!rd_ok)
        begin
            rd_byte = RST_ENTRY;
        end
        else if (bypass_hit_reg)
        begin
            rd_byte = bypass_data_reg;
        end
        else if (valid_reg[rd_addr])
        begin
            rd_byte = ram_rdata;
        end
        else if (rd_ptr == '0)
        begin
            rd_byte = RST_ENTRY0;
        end
        else
        begin
            rd_byte = RST_ENTRY;
        end
    end

endmodule

// ===== hdl/dpbs_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpbs_framer
// Bit sequencer: frame phases, shifter, direct word holding and the
// registered result item.
// ----------------------------------------------------------------------------
module dpbs_framer import dpbs_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               acc,
    input  logic [KIND_W-1:0]  kind,
    input  logic [LEN_W-1:0]   packet_length,
    input  logic [PRE_W-1:0]   preamble_length,
    input  logic [WORD_W-1:0]  direct_word,
    input  mode_t              mode,
    input  logic [BYTE_W-1:0]  rd_byte,
    output logic [PTR_W-1:0]   rd_ptr_next,
    output logic [PTR_W-1:0]   rd_ptr,
    input  logic               res_ready,
    output logic               res_valid,
    output logic               line_bit,
    output logic               packet_request,
    output logic               cutout_pulse,
    output logic               direct_taken
);

    localparam logic [LEN_W-1:0] LEN_CAP =
        LEN_W'(MAX_PACKET_BYTES < 31 ? MAX_PACKET_BYTES : 31);

    typedef enum logic [1:0] {
        PH_PRE   = 2'd0,
        PH_DATA  = 2'd1,
        PH_CHECK = 2'd2,
        PH_STOP  = 2'd3
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic [PRE_W-1:0]   preamble_reg, preamble_next;
    logic [WORD_W-1:0]  shift_reg, shift_next;
    logic [BITS_W-1:0]  bits_reg, bits_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [BYTE_W-1:0]  xor_reg, xor_next;
    logic               active_reg, active_next;
    logic               pending_reg, pending_next;
    logic [WORD_W-1:0]  held_reg, held_next;
    logic               valid_reg;
    logic               line_reg, line_next;
    logic               request_reg, request_next;
    logic               cutout_reg, cutout_next;
    logic               taken_reg, taken_next;
    logic               tick;
    kind_t              kind_c;

    assign kind_c      = kind_t'(kind);
    assign tick        = acc && (kind_c == KIND_TICK);
    assign rd_ptr_next = ptr_next;
    assign rd_ptr      = ptr_reg;

    always_comb
    begin
        phase_next    = phase_reg;
        length_next   = length_reg;
        preamble_next = preamble_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        ptr_next      = ptr_reg;
        xor_next      = xor_reg;
        active_next   = active_reg;
        pending_next  = pending_reg;
        held_next     = held_reg;
        line_next     = 1'b1;
        request_next  = 1'b0;
        cutout_next   = 1'b0;
        taken_next    = 1'b0;

        if (acc && kind_c == KIND_HEADER)
        begin
            length_next   = (packet_length > LEN_CAP) ? LEN_CAP : packet_length;
            preamble_next = preamble_length;
        end

        if (acc && kind_c == KIND_DIRECT)
        begin
            held_next    = direct_word;
            pending_next = 1'b1;
        end

        if (tick)
        begin
            if (bits_reg == '0)
            begin
                if (mode.direct_mode)
                begin
                    if (pending_reg)
                    begin
                        shift_next   = held_reg;
                        bits_next    = DIRECT_BITS;
                        pending_next = 1'b0;
                        active_next  = 1'b1;
                        taken_next   = 1'b1;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_PRE:
                        begin
                            request_next = 1'b1;
                            active_next  = 1'b0;
                            bits_next    = BITS_W'(preamble_reg);
                            phase_next   = PH_DATA;
                            ptr_next     = '0;
                            xor_next     = '0;
                        end
                        PH_DATA:
                        begin
                            if (length_reg != '0)
                            begin
                                active_next = 1'b1;
                                bits_next   = DATA_BITS;
                                xor_next    = xor_reg ^ rd_byte;
                                shift_next  = WORD_W'(rd_byte);
                                ptr_next    = ptr_reg + 1'b1;
                                if (ptr_next >= length_reg)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            else
                            begin
                                active_next = 1'b0;
                            end
                        end
                        PH_CHECK:
                        begin
                            active_next = 1'b1;
                            bits_next   = CHECK_BITS;
                            shift_next  = WORD_W'({xor_reg, 1'b1});
                            phase_next  = mode.cutout_enable ? PH_STOP : PH_PRE;
                        end
                        PH_STOP:
                        begin
                            cutout_next = 1'b1;
                            active_next = 1'b0;
                            bits_next   = '0;
                            phase_next  = PH_PRE;
                        end
                        default:
                        begin
                            phase_next = PH_PRE;
                        end
                    endcase
                end
            end

            if (bits_next != '0)
            begin
                bits_next = bits_next - 1'b1;
            end
            line_next = active_next ? shift_next[bits_next[4:0]] : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_PRE;
            length_reg   <= RST_LENGTH;
            preamble_reg <= RST_PREAMBLE;
            shift_reg    <= '0;
            bits_reg     <= '0;
            ptr_reg      <= '0;
            xor_reg      <= '0;
            active_reg   <= 1'b0;
            pending_reg  <= 1'b0;
            held_reg     <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            length_reg   <= length_next;
            preamble_reg <= preamble_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            ptr_reg      <= ptr_next;
            xor_reg      <= xor_next;
            active_reg   <= active_next;
            pending_reg  <= pending_next;
            held_reg     <= held_next;
            if (tick)
            begin
                valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            line_reg    <= line_next;
            request_reg <= request_next;
            cutout_reg  <= cutout_next;
            taken_reg   <= taken_next;
        end
    end

    assign res_valid      = valid_reg;
    assign line_bit       = line_reg;
    assign packet_request = request_reg;
    assign cutout_pulse   = cutout_reg;
    assign direct_taken   = taken_reg;

endmodule

// ===== hdl/dcc_packet_bit_serializer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_packet_bit_serializer
// DCC line bit serializer for framed packets and raw direct words.
// ----------------------------------------------------------------------------
// Items stream back to back while no result is stalled; a
// bit tick yields one result item in the next cycle through an output register.
// The next item is taken in any cycle in which no result is held or the held
// result is accepted; a stalled result holds off the item channel. Packet
// bytes live in a RAM read ahead at the next byte pointer; a byte
// written just before it is read is forwarded. Entries not yet written read as
// their reset values, so no clearing pass is needed after reset.
module dcc_packet_bit_serializer import dpbs_pkg::*; #(
    parameter int MAX_PACKET_BYTES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dpbs_in_if.sink     item,
    dpbs_out_if.source  result,
    dpbs_cfg_if.sink    cfg
);

    mode_t             mode_reg;
    store_wr_t         wr;
    logic              acc;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [PTR_W-1:0]  rd_ptr;
    logic [BYTE_W-1:0] rd_byte;

    assign item.ready = !result.valid || result.ready;
    assign acc        = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.addr)
                CFG_CUTOUT: mode_reg.cutout_enable <= cfg.data[0];
                CFG_DIRECT: mode_reg.direct_mode   <= cfg.data[0];
                default:    mode_reg               <= mode_reg;
            endcase
        end
    end

    assign wr.en    = acc && (kind_t'(item.kind) == KIND_BYTE);
    assign wr.idx   = item.byte_index;
    assign wr.value = item.byte_value;

    dpbs_store #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .rd_ptr_next (rd_ptr_next),
        .rd_ptr      (rd_ptr),
        .rd_byte     (rd_byte)
    );

    dpbs_framer #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_framer (
        .clk             (clk),
        .rst_n           (rst_n),
        .acc             (acc),
        .kind            (item.kind),
        .packet_length   (item.packet_length),
        .preamble_length (item.preamble_length),
        .direct_word     (item.direct_word),
        .mode            (mode_reg),
        .rd_byte         (rd_byte),
        .rd_ptr_next     (rd_ptr_next),
        .rd_ptr          (rd_ptr),
        .res_ready       (result.ready),
        .res_valid       (result.valid),
        .line_bit        (result.line_bit),
        .packet_request  (result.packet_request),
        .cutout_pulse    (result.cutout_pulse),
        .direct_taken    (result.direct_taken)
    );

endmodule

// ===== tb/dcc_packet_bit_serializer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_packet_bit_serializer_tb
// Self-checking bench for the DCC packet bit serializer. A scoreboard tracks
// the packet store, header, framing phase and direct-word state, and predicts
// the line bit, packet request, cutout pulse and direct-taken flag of every
// bit tick. Directed items hit the field extremes; random packet and direct
// sequences then run under all four mode settings, with random idle cycles
// on the item and result channels.
// ----------------------------------------------------------------------------
module dcc_packet_bit_serializer_tb;
    import dpbs_pkg::*;

    localparam int MAX_BYTES = 16;
    localparam int LEN_CAP   = (MAX_BYTES < 31) ? MAX_BYTES : 31;

    typedef struct packed {
        kind_t               kind;
        logic [INDEX_W-1:0]  byte_index;
        logic [BYTE_W-1:0]   byte_value;
        logic [LEN_W-1:0]    packet_length;
        logic [PRE_W-1:0]    preamble_length;
        logic [WORD_W-1:0]   direct_word;
    } in_item_t;

    typedef struct packed {
        logic line_bit;
        logic packet_request;
        logic cutout_pulse;
        logic direct_taken;
    } bit_result_t;

    typedef enum logic [1:0] {
        PH_PREAMBLE,
        PH_BYTES,
        PH_CHECKSUM,
        PH_CUTOUT
    } frame_phase_t;

    class line_bit_scoreboard;
        logic [BYTE_W-1:0]  store [MAX_BYTES];
        logic [LEN_W-1:0]   hdr_length;
        logic [PRE_W-1:0]   hdr_preamble;
        logic [WORD_W-1:0]  shift;
        logic [BITS_W-1:0]  bits_left;
        frame_phase_t       phase;
        logic [PTR_W-1:0]   ptr;
        logic [BYTE_W-1:0]  xor_acc;
        logic               active;
        logic               word_pending;
        logic [WORD_W-1:0]  held;
        logic               cutout_on;
        logic               direct_on;
        bit_result_t        expected_bits[$];
        int                 errors;
        int                 checked;
        int                 requests;
        int                 cutouts;
        int                 taken;

        function new();
            foreach (store[i])
                store[i] = RST_ENTRY;
            store[0]     = RST_ENTRY0;
            hdr_length   = RST_LENGTH;
            hdr_preamble = RST_PREAMBLE;
            shift        = '0;
            bits_left    = '0;
            phase        = PH_PREAMBLE;
            ptr          = '0;
            xor_acc      = '0;
            active       = 1'b0;
            word_pending = 1'b0;
            held         = '0;
            cutout_on    = 1'b0;
            direct_on    = 1'b0;
            errors       = 0;
            checked      = 0;
            requests     = 0;
            cutouts      = 0;
            taken        = 0;
        endfunction

        function void set_reg(input logic [CFG_A_W-1:0] idx, input logic value);
            if (idx == CFG_CUTOUT)
                cutout_on = value;
            else if (idx == CFG_DIRECT)
                direct_on = value;
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction

        function void note_item(input in_item_t it);
            bit_result_t       r;
            logic [BYTE_W-1:0] v;
            int unsigned       len;
            r = '0;
            case (it.kind)
                KIND_BYTE:
                begin
                    if (int'(it.byte_index) < MAX_BYTES)
                        store[it.byte_index] = it.byte_value;
                end
                KIND_HEADER:
                begin
                    len = it.packet_length;
                    if (len > LEN_CAP)
                        len = LEN_CAP;
                    hdr_length   = LEN_W'(len);
                    hdr_preamble = it.preamble_length;
                end
                KIND_DIRECT:
                begin
                    held         = it.direct_word;
                    word_pending = 1'b1;
                end
                default:
                begin
                    if (bits_left == 0)
                    begin
                        if (direct_on)
                        begin
                            if (word_pending)
                            begin
                                shift          = held;
                                bits_left      = DIRECT_BITS;
                                word_pending   = 1'b0;
                                active         = 1'b1;
                                r.direct_taken = 1'b1;
                            end
                            else
                            begin
                                active = 1'b0;
                            end
                        end
                        else
                        begin
                            case (phase)
                                PH_PREAMBLE:
                                begin
                                    r.packet_request = 1'b1;
                                    active    = 1'b0;
                                    bits_left = BITS_W'(hdr_preamble);
                                    phase     = PH_BYTES;
                                    ptr       = '0;
                                    xor_acc   = '0;
                                end
                                PH_BYTES:
                                begin
                                    if (hdr_length != 0)
                                    begin
                                        v         = (int'(ptr) < MAX_BYTES) ? store[ptr] : '0;
                                        active    = 1'b1;
                                        bits_left = DATA_BITS;
                                        xor_acc   = xor_acc ^ v;
                                        shift     = WORD_W'(v);
                                        ptr       = ptr + 1'b1;
                                        if (ptr >= hdr_length)
                                            phase = PH_CHECKSUM;
                                    end
                                    else
                                    begin
                                        active = 1'b0;
                                    end
                                end
                                PH_CHECKSUM:
                                begin
                                    active    = 1'b1;
                                    bits_left = CHECK_BITS;
                                    shift     = WORD_W'({xor_acc, 1'b1});
                                    phase     = cutout_on ? PH_CUTOUT : PH_PREAMBLE;
                                end
                                default:
                                begin
                                    r.cutout_pulse = 1'b1;
                                    active    = 1'b0;
                                    bits_left = '0;
                                    phase     = PH_PREAMBLE;
                                end
                            endcase
                        end
                    end
                    if (bits_left != 0)
                        bits_left = bits_left - 1'b1;
                    r.line_bit = active ? shift[bits_left[4:0]] : 1'b1;
                    expected_bits.push_back(r);
                end
            endcase
        endfunction

        function void check_bit(input bit_result_t got);
            bit_result_t exp_bit;
            if (expected_bits.size() == 0)
            begin
                $error("result item with no expected bit: %b", got);
                errors++;
                return;
            end
            exp_bit = expected_bits.pop_front();
            checked++;
            requests += exp_bit.packet_request;
            cutouts  += exp_bit.cutout_pulse;
            taken    += exp_bit.direct_taken;
            if (got.line_bit !== exp_bit.line_bit)
            begin
                $error("line_bit: expected %0b, got %0b", exp_bit.line_bit, got.line_bit);
                errors++;
            end
            if (got.packet_request !== exp_bit.packet_request)
            begin
                $error("packet_request: expected %0b, got %0b",
                       exp_bit.packet_request, got.packet_request);
                errors++;
            end
            if (got.cutout_pulse !== exp_bit.cutout_pulse)
            begin
                $error("cutout_pulse: expected %0b, got %0b",
                       exp_bit.cutout_pulse, got.cutout_pulse);
                errors++;
            end
            if (got.direct_taken !== exp_bit.direct_taken)
            begin
                $error("direct_taken: expected %0b, got %0b",
                       exp_bit.direct_taken, got.direct_taken);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic tx_steady;
    logic rx_steady;
    int   items_sent;
    line_bit_scoreboard line_sb;

    dpbs_in_if  item_bus ();
    dpbs_out_if result_bus ();
    dpbs_cfg_if cfg_bus ();

    dcc_packet_bit_serializer #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("** dcc_packet_bit_serializer: FAILED **");
        $finish;
    end

    function automatic in_item_t random_item(input kind_t k);
        in_item_t it;
        it.kind            = k;
        it.byte_index      = INDEX_W'($urandom);
        it.byte_value      = BYTE_W'($urandom);
        it.packet_length   = LEN_W'($urandom);
        it.preamble_length = PRE_W'($urandom);
        it.direct_word     = $urandom;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_steady = ~tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        repeat (gap)
        begin
            item_bus.valid = 1'b0;
            @(negedge clk);
        end
        item_bus.kind            = it.kind;
        item_bus.byte_index      = it.byte_index;
        item_bus.byte_value      = it.byte_value;
        item_bus.packet_length   = it.packet_length;
        item_bus.preamble_length = it.preamble_length;
        item_bus.direct_word     = it.direct_word;
        item_bus.valid           = 1'b1;
        do
            @(posedge clk);
        while (!item_bus.ready);
        line_sb.note_item(it);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(random_item(KIND_TICK));
    endtask

    task automatic send_byte(input int idx, input logic [BYTE_W-1:0] value);
        in_item_t it;
        it            = random_item(KIND_BYTE);
        it.byte_index = INDEX_W'(idx);
        it.byte_value = value;
        send_item(it);
    endtask

    task automatic send_header(input int len, input int pre);
        in_item_t it;
        it                 = random_item(KIND_HEADER);
        it.packet_length   = LEN_W'(len);
        it.preamble_length = PRE_W'(pre);
        send_item(it);
    endtask

    task automatic send_direct(input logic [WORD_W-1:0] word);
        in_item_t it;
        it             = random_item(KIND_DIRECT);
        it.direct_word = word;
        send_item(it);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_bus.valid = 1'b0;
        while (line_sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic value);
        @(negedge clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.addr  = idx;
        cfg_bus.data  = value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        line_sb.set_reg(idx, value);
    endtask

    task automatic set_modes(input logic cutout, input logic direct);
        drain_results();
        repeat (4) @(posedge clk);
        write_reg(CFG_CUTOUT, cutout);
        write_reg(CFG_DIRECT, direct);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic run_phase(input int budget);
        int start;
        int len;
        int pre;
        int ticks;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                repeat (6) send_item(random_item(kind_t'($urandom_range(0, 3))));
            end
            else if (line_sb.direct_on)
            begin
                send_direct($urandom);
                if ($urandom_range(0, 4) == 0)
                    send_direct($urandom);
                ticks = 32 + $urandom_range(0, 6);
                repeat (ticks) send_tick();
            end
            else
            begin
                len = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
                pre = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
                send_header(len, pre);
                if (len > LEN_CAP)
                    len = LEN_CAP;
                for (int i = 0; i < len; i++)
                    send_byte(i, BYTE_W'($urandom));
                ticks = (len == 0) ? pre + 4 : pre + 9 * len + 12;
                repeat (ticks) send_tick();
            end
        end
    endtask

    initial
    begin
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            if ($urandom_range(0, 39) == 0)
                rx_steady = ~rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 12);
            repeat (stall)
            begin
                @(negedge clk);
                result_bus.ready = 1'b0;
            end
            @(negedge clk);
            result_bus.ready = 1'b1;
            do
                @(posedge clk);
            while (!(result_bus.valid && result_bus.ready));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid && result_bus.ready)
            line_sb.check_bit({result_bus.line_bit, result_bus.packet_request,
                               result_bus.cutout_pulse, result_bus.direct_taken});
    end

    initial
    begin
        line_sb                  = new();
        rst_n                    = 1'b0;
        tx_steady                = 1'b0;
        rx_steady                = 1'b0;
        items_sent               = 0;
        item_bus.valid           = 1'b0;
        item_bus.kind            = KIND_TICK;
        item_bus.byte_index      = '0;
        item_bus.byte_value      = '0;
        item_bus.packet_length   = '0;
        item_bus.preamble_length = '0;
        item_bus.direct_word     = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.addr             = CFG_CUTOUT;
        cfg_bus.data             = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        set_modes(1'b0, 1'b0);
        send_header(1, 0);
        send_byte(0, 8'hFF);
        send_byte(15, 8'h00);
        send_direct(32'hFFFF_FFFF);
        send_direct(32'h0000_0000);
        repeat (6) send_tick();
        send_header(31, 63);
        send_header(0, 2);
        repeat (6) send_tick();
        send_byte(1, 8'h5A);
        send_header(2, 1);
        repeat (4) send_tick();

        run_phase(80);
        drain_results();
        run_phase(80);
        set_modes(1'b1, 1'b0);
        run_phase(150);
        set_modes(1'b0, 1'b1);
        run_phase(140);
        set_modes(1'b1, 1'b1);
        run_phase(130);
        set_modes(1'b0, 1'b0);
        run_phase(120);
        set_modes(1'b1, 1'b0);
        run_phase(120);

        drain_results();
        repeat (20) @(posedge clk);
        line_sb.errors += line_sb.pending();
        $display("Sent %0d items over four mode settings; checked %0d line bits.",
                 items_sent, line_sb.checked);
        $display("Saw %0d packet requests, %0d cutout slots, %0d direct words taken.",
                 line_sb.requests, line_sb.cutouts, line_sb.taken);
        if (line_sb.errors == 0)
            $display("** dcc_packet_bit_serializer: PASSED **");
        else
            $display("** dcc_packet_bit_serializer: FAILED **");
        $finish;
    end

endmodule
